[rtl/core/cpc_pkg.sv]
`timescale 1ns / 1ps
// Package for the color pair cache: beat types, controller/datapath command
// and status structs, state encoding and the color scoring helpers. No dependencies.
package cpc_pkg;

  localparam int unsigned COLOR_COUNT_DEF = 8;
  localparam int unsigned PAIR_W          = 7;
  localparam int unsigned MAXP_W          = 9;
  localparam logic [MAXP_W-1:0] MAX_PAIRS_RST = 9'd64;

  // Score weights for a candidate whose colors differ from the request.
  localparam logic [3:0] BG_BW_COST     = 4'd3;
  localparam logic [3:0] BG_GREY_NEAR   = 4'd1;
  localparam logic [3:0] BG_GREY_FAR    = 4'd2;
  localparam logic [3:0] FG_BW_COST     = 4'd5;
  localparam logic [3:0] FG_GREY_NEAR   = 4'd1;
  localparam logic [3:0] FG_GREY_FAR    = 4'd3;
  localparam logic [7:0] COLOR_BLACK    = 8'd0;
  localparam logic [7:0] COLOR_WHITE    = 8'd15;
  localparam logic [7:0] COLOR_GREY_LO  = 8'd7;
  localparam logic [7:0] COLOR_GREY_HI  = 8'd8;

  typedef struct packed {
    logic [7:0] fg;
    logic [7:0] bg;
  } in_beat_t;

  typedef struct packed {
    logic [PAIR_W-1:0] pair;
    logic              allocated;
    logic [2:0]        mapped_fg;
    logic [2:0]        mapped_bg;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_HIT,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_ALLOC,
    RES_HIT,
    RES_BEST
  } res_sel_t;

  typedef struct packed {
    logic     latch_in;
    logic     rd_key;
    logic     alloc_wr;
    logic     best_wr;
    logic     scan_clr;
    logic     scan_step;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic oor;
    logic hit;
    logic room;
    logic scan_last;
    logic out_free;
  } sts_t;

  function automatic logic is_grey(input logic [7:0] c);
    begin
      is_grey = (c == COLOR_GREY_LO) || (c == COLOR_GREY_HI);
    end
  endfunction

  function automatic logic [3:0] pair_score(input logic [7:0] rfg, input logic [7:0] rbg,
                                            input logic [7:0] cfg, input logic [7:0] cbg);
    logic [3:0] s;
    begin
      s = '0;
      if (rbg != cbg) begin
        if (rbg == COLOR_BLACK || rbg == COLOR_WHITE) s = s + BG_BW_COST;
        if (is_grey(rbg)) s = s + (is_grey(cbg) ? BG_GREY_NEAR : BG_GREY_FAR);
      end
      if (rfg != cfg) begin
        if (rfg == COLOR_BLACK || rfg == COLOR_WHITE) s = s + FG_BW_COST;
        if (is_grey(rfg)) s = s + (is_grey(cfg) ? FG_GREY_NEAR : FG_GREY_FAR);
      end
      pair_score = s;
    end
  endfunction

  // Terminal color order; indices above 7 fold back onto 1..7 first.
  function automatic logic [2:0] term_color(input logic [3:0] c);
    begin
      case (c)
        4'd0:    term_color = 3'd0;
        4'd1:    term_color = 3'd4;
        4'd2:    term_color = 3'd2;
        4'd3:    term_color = 3'd6;
        4'd4:    term_color = 3'd1;
        4'd5:    term_color = 3'd5;
        4'd6:    term_color = 3'd3;
        4'd7:    term_color = 3'd7;
        4'd8:    term_color = 3'd4;
        4'd9:    term_color = 3'd2;
        4'd10:   term_color = 3'd6;
        4'd11:   term_color = 3'd1;
        4'd12:   term_color = 3'd5;
        4'd13:   term_color = 3'd3;
        4'd14:   term_color = 3'd7;
        default: term_color = 3'd4;
      endcase
    end
  endfunction

endpackage

[rtl/core/cpc_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine of the color pair cache.
// Depends on cpc_pkg; drives commands into cpc_datapath and reads its status.
module cpc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cpc_pkg::sts_t sts,
  output cpc_pkg::cmd_t cmd
);

  cpc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cpc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_sel = cpc_pkg::RES_ZERO;
    in_stall  = 1'b1;
    case (state_r)
      cpc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = cpc_pkg::ST_CHECK;
        end
      end
      cpc_pkg::ST_CHECK: begin
        if (sts.oor) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = cpc_pkg::RES_ZERO;
          state_nxt    = cpc_pkg::ST_RESP;
        end else if (sts.hit) begin
          cmd.rd_key = 1'b1;
          state_nxt  = cpc_pkg::ST_HIT;
        end else if (sts.room) begin
          cmd.alloc_wr = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_sel  = cpc_pkg::RES_ALLOC;
          state_nxt    = cpc_pkg::ST_RESP;
        end else begin
          cmd.scan_clr = 1'b1;
          state_nxt    = cpc_pkg::ST_SCAN;
        end
      end
      cpc_pkg::ST_HIT: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = cpc_pkg::RES_HIT;
        state_nxt    = cpc_pkg::ST_RESP;
      end
      cpc_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = cpc_pkg::ST_DRAIN;
      end
      cpc_pkg::ST_DRAIN: begin
        state_nxt = cpc_pkg::ST_COMMIT;
      end
      cpc_pkg::ST_COMMIT: begin
        cmd.best_wr  = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_sel  = cpc_pkg::RES_BEST;
        state_nxt    = cpc_pkg::ST_RESP;
      end
      cpc_pkg::ST_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = cpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cpc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/cpc_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the color pair cache: slot table, counters, scan scorer and
// output register. Depends on cpc_pkg; steered by cpc_ctrl.
module cpc_datapath #(
  parameter int unsigned COLOR_COUNT = cpc_pkg::COLOR_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cpc_pkg::in_beat_t              in_data,
  input  logic                           cfg_wr,
  input  logic [cpc_pkg::MAXP_W-1:0]     cfg_data,
  input  logic                           out_stall,
  output logic                           out_valid,
  output cpc_pkg::out_beat_t             out_data,
  input  cpc_pkg::cmd_t                  cmd,
  output cpc_pkg::sts_t                  sts
);

  localparam int unsigned SLOTS = COLOR_COUNT * COLOR_COUNT;
  localparam int unsigned CW    = $clog2(COLOR_COUNT);
  localparam int unsigned KW    = $clog2(SLOTS);
  localparam int unsigned NW    = $clog2(SLOTS + 1);
  localparam logic [7:0]    CC8      = 8'(COLOR_COUNT);
  localparam logic [KW-1:0] CC_K     = KW'(COLOR_COUNT);
  localparam logic [CW-1:0] BG_LAST  = CW'(COLOR_COUNT - 1);
  localparam logic [KW-1:0] KEY_LAST = KW'(SLOTS - 1);
  localparam int unsigned PW = cpc_pkg::PAIR_W;

  logic [7:0]                    fg_r, bg_r;
  logic [KW-1:0]                 key_r;
  logic                          oor_r;
  logic [cpc_pkg::MAXP_W-1:0]    max_pairs_r;
  logic [NW-1:0]                 count_r;
  logic [SLOTS-1:0]              valid_r;
  logic [PW-1:0]                 mem [SLOTS];
  logic [PW-1:0]                 rd_data_r;
  logic [KW-1:0]                 si_r;
  logic [CW-1:0]                 sf_r, sb_r;
  logic                          pend_r, sv_r, have_r;
  logic [3:0]                    sc_r, best_r;
  logic [PW-1:0]                 best_pair_r;
  cpc_pkg::out_beat_t            res_r, res_nxt, out_r;
  logic                          out_valid_r;

  logic [9:0]    cnt_p1;
  logic          wr_en;
  logic [PW-1:0] wr_data;
  logic          rd_en;
  logic [KW-1:0] rd_addr;

  assign cnt_p1  = 10'(count_r) + 10'd1;
  assign wr_en   = cmd.alloc_wr | cmd.best_wr;
  assign wr_data = cmd.alloc_wr ? cnt_p1[PW-1:0] : best_pair_r;
  assign rd_en   = cmd.rd_key | cmd.scan_step;
  assign rd_addr = cmd.scan_step ? si_r : key_r;

  assign sts.oor       = oor_r;
  assign sts.hit       = valid_r[key_r];
  assign sts.room      = cnt_p1 < 10'(max_pairs_r);
  assign sts.scan_last = (si_r == KEY_LAST);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[key_r] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      fg_r  <= in_data.fg;
      bg_r  <= in_data.bg;
      key_r <= KW'(in_data.fg[CW-1:0]) * CC_K + KW'(in_data.bg[CW-1:0]);
      oor_r <= (in_data.fg >= CC8) || (in_data.bg >= CC8);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pairs_r <= cpc_pkg::MAX_PAIRS_RST;
      count_r     <= '0;
      valid_r     <= '0;
    end else begin
      if (cfg_wr) max_pairs_r <= cfg_data;
      if (wr_en) begin
        count_r        <= count_r + NW'(1);
        valid_r[key_r] <= 1'b1;
      end
    end
  end

  // Scan: one slot per cycle, scored in the cycle after its read is issued.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      si_r <= '0;
      sf_r <= '0;
      sb_r <= '0;
    end else if (cmd.scan_step) begin
      si_r <= si_r + KW'(1);
      if (sb_r == BG_LAST) begin
        sb_r <= '0;
        sf_r <= sf_r + CW'(1);
      end else begin
        sb_r <= sb_r + CW'(1);
      end
    end
    if (cmd.scan_step) begin
      sv_r <= valid_r[si_r];
      sc_r <= cpc_pkg::pair_score(fg_r, bg_r, 8'(sf_r), 8'(sb_r));
    end
    if (cmd.scan_clr) begin
      have_r      <= 1'b0;
      best_pair_r <= '0;
    end else if (pend_r && sv_r && (!have_r || sc_r < best_r)) begin
      have_r      <= 1'b1;
      best_r      <= sc_r;
      best_pair_r <= rd_data_r;
    end
  end

  always_comb begin
    res_nxt = '0;
    case (cmd.res_sel)
      cpc_pkg::RES_ZERO: res_nxt = '0;
      cpc_pkg::RES_ALLOC: begin
        res_nxt.pair      = cnt_p1[PW-1:0];
        res_nxt.allocated = 1'b1;
        res_nxt.mapped_fg = cpc_pkg::term_color(fg_r[3:0]);
        res_nxt.mapped_bg = cpc_pkg::term_color(bg_r[3:0]);
      end
      cpc_pkg::RES_HIT:  res_nxt.pair = rd_data_r;
      cpc_pkg::RES_BEST: res_nxt.pair = best_pair_r;
      default:           res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) res_r <= res_nxt;
    if (cmd.out_load) out_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

[rtl/core/color_pair_cache.sv]
`timescale 1ns / 1ps
// Top level of the color pair cache: joins the controller and the datapath.
// Depends on cpc_pkg, cpc_ctrl and cpc_datapath.
//
//   port group | direction | flow control  | beat contents
//   in_*       | input     | valid / stall | fg, bg request colors
//   out_*      | output    | valid / stall | pair, allocated, mapped_fg, mapped_bg
//   cfg_*      | input     | valid / ready | max_pairs (9 bits)
//
// A request that hits, is out of range or allocates a new pair passes CHECK,
// then HIT for a hit, then RESP for its result beat. When no pairs are left, the
// datapath walks every slot of the table through its single memory read port,
// one slot per cycle, then passes DRAIN and COMMIT before RESP.
// One request is in flight at a time.
// Reset is synchronous and active low; it clears the slot valid bits, the
// stored count and the output valid, and loads max_pairs with 64.
// A stalled result stays in the output register while the next request is
// already accepted and worked on.
module color_pair_cache #(
  parameter int unsigned COLOR_COUNT = cpc_pkg::COLOR_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  cpc_pkg::in_beat_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output cpc_pkg::out_beat_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cpc_pkg::MAXP_W-1:0]  cfg_data
);

  cpc_pkg::cmd_t cmd;
  cpc_pkg::sts_t sts;

  // Users must write the register only while idle; the block does not enforce it.
  assign cfg_ready = 1'b1;

  cpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cpc_datapath #(
    .COLOR_COUNT (COLOR_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_wr    (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

[rtl/core/cpc_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the color pair cache, bound to the top level.
// Depends on cpc_pkg and color_pair_cache.
module cpc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input cpc_pkg::out_beat_t out_data
);

  // Only one request is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while the previous one is in flight");

  // Mapped colors are reported only for a newly allocated pair.
  a_mapped_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.allocated |-> out_data.mapped_fg == 3'd0 &&
    out_data.mapped_bg == 3'd0)
    else $error("mapped colors set without an allocation");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind color_pair_cache cpc_checker u_cpc_checker (.*);
